// ----- sv/b64_pkg.sv -----
// Shared types, constants and character-mapping functions for the Base64 stream codec.
// No dependencies; every other file of the codec imports this package.
`default_nettype none

package b64_pkg;

    localparam logic       MODE_ENCODE     = 1'b0;
    localparam logic       MODE_DECODE     = 1'b1;
    localparam logic [7:0] PAD_CHAR        = 8'h3D;
    localparam int         CMD_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } b64_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } b64_out_t;

    // One finished group, handed from the front to the back.
    typedef struct packed {
        logic        enc;     // 1: emit alphabet characters, 0: emit bytes
        logic [1:0]  n_m1;    // number of results minus one
        logic [1:0]  pads;    // trailing '=' characters (encode only)
        logic        last;    // final result carries out_last
        logic [23:0] bits;
    } b64_cmd_t;

    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] s;
        s = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s = 6'd62;
        end else if (c == 8'h2F) begin
            s = 6'd63;
        end
        return s;
    endfunction

    function automatic logic [7:0] alphabet(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26) begin
            c = 8'h41 + {2'b00, s};
        end else if (s < 6'd52) begin
            c = 8'h61 + {2'b00, s} - 8'd26;
        end else if (s < 6'd62) begin
            c = 8'h30 + {2'b00, s} - 8'd52;
        end else if (s == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/b64_cmdq.sv -----
// Short command queue between the codec's front and back.
// Depends on b64_pkg for the command type.
`default_nettype none

module b64_cmdq
    import b64_pkg::*;
#(
    parameter int DEPTH = CMD_QUEUE_DEPTH
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     q_push,
    input  wire b64_cmd_t q_wdata,
    output logic          q_full,
    input  wire logic     q_pop,
    output b64_cmd_t      q_head,
    output logic          q_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64_cmd_t        mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign q_full  = (count_reg == CW'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_head  = mem[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (q_push) begin
            mem[wr_ptr_reg] <= q_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (q_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (q_push && !q_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (q_pop && !q_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/b64_front.sv -----
// Front of the codec: takes input items, gathers Base64 groups and issues one
// command per finished group. Holds the mode register. Depends on b64_pkg.
`default_nettype none

module b64_front
    import b64_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cfg_wr,
    input  wire logic    cfg_mode,
    input  wire logic    accept,
    input  wire b64_in_t item,
    output logic         q_push,
    output b64_cmd_t     q_wdata
);

    logic        mode_reg;
    logic [23:0] group_bits_reg, group_bits_next;
    logic [1:0]  group_count_reg, group_count_next;
    logic        pad_seen_reg, pad_seen_next;

    logic [23:0] enc_bits, dec_bits;
    logic [5:0]  sext;
    logic        pad_now;
    logic        issue;
    b64_cmd_t    cmd;

    assign sext    = sextet_of(item.in_byte);
    assign pad_now = (item.in_byte == PAD_CHAR);

    always_comb begin
        unique case (group_count_reg)
            2'd0: enc_bits = group_bits_reg | {item.in_byte, 16'h0000};
            2'd1: enc_bits = group_bits_reg | {8'h00, item.in_byte, 8'h00};
            2'd2: enc_bits = group_bits_reg | {16'h0000, item.in_byte};
            default: enc_bits = group_bits_reg;
        endcase
        unique case (group_count_reg)
            2'd0: dec_bits = group_bits_reg | {sext, 18'd0};
            2'd1: dec_bits = group_bits_reg | {6'd0, sext, 12'd0};
            2'd2: dec_bits = group_bits_reg | {12'd0, sext, 6'd0};
            default: dec_bits = group_bits_reg | {18'd0, sext};
        endcase
    end

    always_comb begin
        group_bits_next  = group_bits_reg;
        group_count_next = group_count_reg;
        pad_seen_next    = pad_seen_reg;
        issue            = 1'b0;
        cmd.enc          = (mode_reg == MODE_ENCODE);
        cmd.n_m1         = 2'd3;
        cmd.pads         = 2'd0;
        cmd.last         = item.in_last;
        cmd.bits         = enc_bits;

        if (mode_reg == MODE_ENCODE) begin
            if (group_count_reg == 2'd2 || item.in_last) begin
                issue = 1'b1;
                // A short tail is padded out to four characters.
                if (group_count_reg == 2'd0) begin
                    cmd.pads = 2'd2;
                end else if (group_count_reg == 2'd1) begin
                    cmd.pads = 2'd1;
                end
                group_bits_next  = '0;
                group_count_next = '0;
                pad_seen_next    = 1'b0;
            end else begin
                group_bits_next  = enc_bits;
                group_count_next = group_count_reg + 1'b1;
            end
        end else begin
            cmd.bits = dec_bits;
            if (group_count_reg != 2'd3) begin
                // A partial group on the last character is dropped.
                if (item.in_last) begin
                    group_bits_next  = '0;
                    group_count_next = '0;
                    pad_seen_next    = 1'b0;
                end else begin
                    group_bits_next  = dec_bits;
                    group_count_next = group_count_reg + 1'b1;
                    pad_seen_next    = pad_seen_reg | (group_count_reg == 2'd2 && pad_now);
                end
            end else begin
                issue = 1'b1;
                priority if (item.in_last && pad_now && pad_seen_reg) begin
                    cmd.n_m1 = 2'd0;
                end else if (item.in_last && pad_now) begin
                    cmd.n_m1 = 2'd1;
                end else begin
                    cmd.n_m1 = 2'd2;
                end
                group_bits_next  = '0;
                group_count_next = '0;
                pad_seen_next    = 1'b0;
            end
        end
    end

    assign q_push  = accept && issue;
    assign q_wdata = cmd;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg        <= MODE_ENCODE;
            group_bits_reg  <= '0;
            group_count_reg <= '0;
            pad_seen_reg    <= 1'b0;
        end else if (cfg_wr) begin
            // A mode change drops any partly gathered group.
            mode_reg        <= cfg_mode;
            group_bits_reg  <= '0;
            group_count_reg <= '0;
            pad_seen_reg    <= 1'b0;
        end else if (accept) begin
            group_bits_reg  <= group_bits_next;
            group_count_reg <= group_count_next;
            pad_seen_reg    <= pad_seen_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/b64_back.sv -----
// Back of the codec: turns each queued command into its results, one per cycle while
// the output register is free or being popped, into it. Depends on b64_pkg.
`default_nettype none

module b64_back
    import b64_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire b64_cmd_t q_head,
    input  wire logic     q_empty,
    output logic          q_pop,
    input  wire logic     pop,
    output logic          empty,
    output b64_out_t      result
);

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    b64_out_t   out_reg;
    logic       fire, final_one;
    logic [5:0] sext;
    logic [7:0] data_byte;
    logic       is_pad;
    b64_out_t   res;

    always_comb begin
        unique case (idx_reg)
            2'd0: sext = q_head.bits[23:18];
            2'd1: sext = q_head.bits[17:12];
            2'd2: sext = q_head.bits[11:6];
            default: sext = q_head.bits[5:0];
        endcase
        unique case (idx_reg)
            2'd0: data_byte = q_head.bits[23:16];
            2'd1: data_byte = q_head.bits[15:8];
            default: data_byte = q_head.bits[7:0];
        endcase
    end

    // The last pads positions of an encoded group are '='.
    assign is_pad    = ({1'b0, idx_reg} + {1'b0, q_head.pads}) >= 3'd4;
    assign final_one = (idx_reg == q_head.n_m1);

    always_comb begin
        if (q_head.enc) begin
            res.out_byte = is_pad ? PAD_CHAR : alphabet(sext);
        end else begin
            res.out_byte = data_byte;
        end
        res.out_last = q_head.last && final_one;
    end

    assign fire   = !q_empty && (!out_valid_reg || pop);
    assign q_pop  = fire && final_one;
    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk) begin
        if (fire) begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                out_valid_reg <= 1'b1;
                idx_reg       <= final_one ? 2'd0 : idx_reg + 1'b1;
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/base64_stream_codec.sv -----
// Top level of the Base64 stream codec: front, command queue and back.
// Depends on b64_pkg, b64_front, b64_cmdq and b64_back.
//
// Streaming Base64 (standard alphabet, '=' padding) encoder/decoder. The mode
// register picks encode (0) or decode (1); a mode write also drops any partly
// gathered group and must be done while the block is idle. The front gathers
// three bytes (encode) or four characters (decode) and queues one command per
// group; the back emits the group's results one per cycle through an output
// register while it is free or being popped. Decoding therefore sustains one
// character per cycle when results are popped; encoding is bound by the back's
// single result per cycle, as it emits four characters per three bytes. The
// first result of a group passes through the command queue and then the output
// register. A trailing partial decode group is discarded without output.
`default_nettype none

module base64_stream_codec
    import b64_pkg::*;
#(
    parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cfg_valid,
    output logic         cfg_ready,
    input  wire logic    cfg_data,
    input  wire logic    push,
    output logic         full,
    input  wire b64_in_t item,
    output logic         empty,
    input  wire logic    pop,
    output b64_out_t     result
);

    logic     q_push, q_full, q_pop, q_empty;
    b64_cmd_t q_wdata, q_head;
    logic     cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign full      = q_full;

    b64_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .cfg_mode (cfg_data),
        .accept   (push && !q_full),
        .item     (item),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    b64_cmdq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_empty (q_empty)
    );

    b64_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command queue read while empty");

    a_enc_four: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_empty && q_head.enc) |-> (q_head.n_m1 == 2'd3 && q_head.pads != 2'd3))
        else $error("encode group not four characters with at most two pads");

    a_dec_nopad: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_empty && !q_head.enc) |-> (q_head.n_m1 != 2'd3 && q_head.pads == 2'd0))
        else $error("decode group with bad result count");

endmodule

`default_nettype wire

// ----- tb/tb_base64_stream_codec.sv -----
// Self-checking testbench for base64_stream_codec: encode and decode traffic
// checked against a behavioral Base64 predictor with random idling on both sides.
// Depends on b64_pkg and the codec RTL.
`default_nettype none

module tb_base64_stream_codec;
    import b64_pkg::*;

    localparam int    CYCLE_LIMIT = 400000;
    localparam int    PHASE_ITEMS = 49;
    localparam int    DRAIN_SLACK = 8;
    localparam string B64_ALPHA   =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct {
        bit         wr;
        bit         md;
        logic [7:0] b;
        bit         l;
        string      fix;
    } dir_row_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cfg_valid = 1'b0;
    logic     cfg_data  = 1'b0;
    logic     push      = 1'b0;
    logic     pop       = 1'b0;
    b64_in_t  item      = '0;
    logic     cfg_ready;
    logic     full;
    logic     empty;
    b64_out_t result;

    // Predictor state.
    logic        cur_mode  = MODE_ENCODE;
    logic [23:0] grp_bits  = '0;
    int          grp_cnt   = 0;
    bit          pad_third = 1'b0;

    b64_out_t    pending_out[$];
    logic [7:0]  msg_bytes[$];
    dir_row_t    dir_rows[$];
    logic        phase_mode[8] = '{MODE_ENCODE, MODE_DECODE, MODE_DECODE, MODE_ENCODE,
                                   MODE_DECODE, MODE_ENCODE, MODE_ENCODE, MODE_DECODE};

    int          err_count  = 0;
    int          cycles     = 0;
    int          burst_left = 0;
    logic        hold_go    = 1'b0;

    // Receiver-side pattern state.
    bit          hold_started = 1'b0;
    int          hold_left    = 0;
    logic [31:0] stall_pat    = '0;
    int          stall_cnt    = 0;

    base64_stream_codec u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[base64_stream_codec] ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] b64_char(input logic [5:0] s);
        return B64_ALPHA[s];
    endfunction

    function automatic logic [5:0] char_value(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
            return 6'(c - 8'h41);
        if (c >= 8'h61 && c <= 8'h7A)
            return 6'(c - 8'h61 + 8'd26);
        if (c >= 8'h30 && c <= 8'h39)
            return 6'(c - 8'h30 + 8'd52);
        if (c == 8'h2B)
            return 6'd62;
        if (c == 8'h2F)
            return 6'd63;
        // Anything else, the pad character included, counts as zero.
        return 6'd0;
    endfunction

    function automatic void add_result(input logic [7:0] v, input logic l);
        b64_out_t r;
        r.out_byte = v;
        r.out_last = l;
        pending_out.push_back(r);
    endfunction

    function automatic void clear_group();
        grp_bits  = '0;
        grp_cnt   = 0;
        pad_third = 1'b0;
    endfunction

    function automatic void codec_predict(input logic [7:0] b, input logic l);
        logic [7:0] b1, b2, b3;
        if (cur_mode == MODE_ENCODE)
        begin
            grp_bits = grp_bits | (24'(b) << (16 - 8 * grp_cnt));
            grp_cnt++;
            if (grp_cnt == 3)
            begin
                add_result(b64_char(grp_bits[23:18]), 1'b0);
                add_result(b64_char(grp_bits[17:12]), 1'b0);
                add_result(b64_char(grp_bits[11:6]), 1'b0);
                add_result(b64_char(grp_bits[5:0]), l);
                clear_group();
            end
            else if (l)
            begin
                add_result(b64_char(grp_bits[23:18]), 1'b0);
                add_result(b64_char(grp_bits[17:12]), 1'b0);
                if (grp_cnt == 2)
                    add_result(b64_char(grp_bits[11:6]), 1'b0);
                else
                    add_result(PAD_CHAR, 1'b0);
                add_result(PAD_CHAR, 1'b1);
                clear_group();
            end
        end
        else
        begin
            if (grp_cnt == 2 && b == PAD_CHAR)
                pad_third = 1'b1;
            grp_bits = grp_bits | (24'(char_value(b)) << (18 - 6 * grp_cnt));
            if (grp_cnt < 3)
            begin
                grp_cnt++;
                // A partial group at the end of a message is dropped silently.
                if (l)
                    clear_group();
            end
            else
            begin
                {b1, b2, b3} = grp_bits;
                if (l && b == PAD_CHAR && pad_third)
                    add_result(b1, 1'b1);
                else if (l && b == PAD_CHAR)
                begin
                    add_result(b1, 1'b0);
                    add_result(b2, 1'b1);
                end
                else
                begin
                    add_result(b1, 1'b0);
                    add_result(b2, 1'b0);
                    add_result(b3, l);
                end
                clear_group();
            end
        end
    endfunction

    task automatic report_error(input string what, input b64_out_t want, input b64_out_t got);
        err_count++;
        if (err_count <= 10)
            $display("mismatch at cycle %0d (%s): expected byte %02h last %0b, got byte %02h last %0b",
                     cycles, what, want.out_byte, want.out_last, got.out_byte, got.out_last);
    endtask

    // Result side: check each transfer, then hold pop low during a hold or pick it from the stall pattern.
    always @(posedge clk)
    begin
        b64_out_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_out.size() == 0)
                report_error("no result pending", '0, result);
            else
            begin
                want = pending_out.pop_front();
                if (result.out_byte !== want.out_byte || result.out_last !== want.out_last)
                    report_error("field", want, result);
            end
        end
        if (hold_go && !hold_started)
        begin
            hold_started = 1'b1;
            hold_left    = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            if (stall_cnt == 0)
            begin
                stall_cnt = 32;
                case ($urandom_range(3))
                    0:       stall_pat = '1;
                    1:       stall_pat = $urandom | $urandom;
                    default: stall_pat = $urandom;
                endcase
            end
            pop <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[31:1]};
            stall_cnt--;
        end
    end

    // Leaves push high after the transfer; a gap in the next call or drain_results lowers it.
    task automatic send_item(input logic [7:0] b, input logic l, input string fix);
        int gap;
        int n0;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(5) == 0) ? 60 : $urandom_range(1, 12);
        end
        burst_left--;
        push          <= 1'b1;
        item.in_byte  <= b;
        item.in_last  <= l;
        do @(posedge clk); while (full);
        n0 = pending_out.size();
        codec_predict(b, l);
        if (fix.len() != 0)
        begin
            while (pending_out.size() > n0)
                void'(pending_out.pop_back());
            for (int i = 0; i < fix.len(); i++)
                add_result(fix[i], l && (i == fix.len() - 1));
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        burst_left = 0;
        while (pending_out.size() != 0)
            @(posedge clk);
        // A dropped partial group leaves nothing to wait for, so give it slack.
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_mode = m;
        clear_group();
    endtask

    function automatic logic [7:0] rand_char();
        return B64_ALPHA[$urandom_range(63)];
    endfunction

    function automatic void make_message(input bit long_msg);
        int len;
        int ng;
        int kind;
        msg_bytes.delete();
        if (cur_mode == MODE_ENCODE)
        begin
            if (long_msg)
                len = $urandom_range(30, 45);
            else if ($urandom_range(7) == 0)
                len = $urandom_range(10, 24);
            else
                len = $urandom_range(1, 9);
            repeat (len) msg_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        kind = $urandom_range(99);
        ng   = long_msg ? $urandom_range(8, 11) : $urandom_range(1, 3);
        if (kind < 80 || long_msg)
        begin
            repeat (ng * 4) msg_bytes.push_back(rand_char());
            case ($urandom_range(2))
                1: msg_bytes[msg_bytes.size() - 1] = PAD_CHAR;
                2:
                begin
                    msg_bytes[msg_bytes.size() - 1] = PAD_CHAR;
                    msg_bytes[msg_bytes.size() - 2] = PAD_CHAR;
                end
                default: ;
            endcase
            if (!long_msg && $urandom_range(9) == 0)
                msg_bytes[$urandom_range(msg_bytes.size() - 1)] = 8'($urandom_range(255));
        end
        else if (kind < 90)
        begin
            // Whole groups followed by a short leftover that never completes.
            repeat (ng * 4) msg_bytes.push_back(rand_char());
            repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom_range(255)));
        end
        else
        begin
            len = $urandom_range(1, 12);
            repeat (len)
            begin
                case ($urandom_range(2))
                    0:       msg_bytes.push_back(PAD_CHAR);
                    1:       msg_bytes.push_back(rand_char());
                    default: msg_bytes.push_back(8'($urandom_range(255)));
                endcase
            end
        end
    endfunction

    task automatic send_message(input bit truncate);
        for (int i = 0; i < msg_bytes.size(); i++)
            send_item(msg_bytes[i], (i == msg_bytes.size() - 1) && !truncate, "");
    endtask

    initial
    begin : stimulus
        int  sent;
        bit  paused;
        bit  trunc;

        // Encode rows first, relying on the mode after reset.
        dir_rows.push_back('{1'b0, MODE_ENCODE, 8'h4D, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_ENCODE, 8'h61, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_ENCODE, 8'h6E, 1'b0, "TWFu"});
        dir_rows.push_back('{1'b0, MODE_ENCODE, 8'h4D, 1'b1, "TQ=="});
        dir_rows.push_back('{1'b0, MODE_ENCODE, 8'hFF, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_ENCODE, 8'h00, 1'b1, "/wA="});
        dir_rows.push_back('{1'b0, MODE_ENCODE, 8'hFF, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_ENCODE, 8'hFF, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_ENCODE, 8'hFF, 1'b1, "////"});
        // This partial group is thrown away by the mode write that follows.
        dir_rows.push_back('{1'b0, MODE_ENCODE, 8'h00, 1'b0, ""});
        dir_rows.push_back('{1'b1, MODE_DECODE, 8'h54, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_DECODE, 8'h57, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_DECODE, 8'h46, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_DECODE, 8'h75, 1'b0, "Man"});
        // Pad and a foreign character inside a group that is not final.
        dir_rows.push_back('{1'b0, MODE_DECODE, 8'h2F, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_DECODE, 8'h2B, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_DECODE, 8'hFF, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_DECODE, PAD_CHAR, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_DECODE, 8'h54, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_DECODE, 8'h51, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_DECODE, PAD_CHAR, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_DECODE, PAD_CHAR, 1'b1, "M"});
        dir_rows.push_back('{1'b0, MODE_DECODE, 8'h54, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_DECODE, 8'h57, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_DECODE, 8'h45, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_DECODE, PAD_CHAR, 1'b1, "Ma"});
        dir_rows.push_back('{1'b0, MODE_DECODE, 8'h51, 1'b0, ""});
        dir_rows.push_back('{1'b0, MODE_DECODE, 8'h00, 1'b1, ""});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].wr)
                write_mode(dir_rows[i].md);
            send_item(dir_rows[i].b, dir_rows[i].l, dir_rows[i].fix);
        end

        paused = 1'b0;
        for (int ph = 0; ph < 8; ph++)
        begin
            write_mode(phase_mode[ph]);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if (ph == 1 && !hold_go && sent >= 10)
                begin
                    // Receiver holds off while a long message keeps pushing.
                    hold_go = 1'b1;
                    make_message(1'b1);
                    burst_left = 64;
                    send_message(1'b0);
                    sent += msg_bytes.size();
                    continue;
                end
                if (ph == 4 && !paused && sent >= 25)
                begin
                    paused = 1'b1;
                    drain_results();
                end
                make_message(1'b0);
                trunc = (sent + msg_bytes.size() >= PHASE_ITEMS) && ($urandom_range(2) == 0);
                send_message(trunc);
                sent += msg_bytes.size();
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (pending_out.size() != 0)
            err_count++;
        if (err_count == 0)
            $display("[base64_stream_codec] OK");
        else
            $display("[base64_stream_codec] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
